>>> rtl/ncpu_pkg.sv
package ncpu_pkg;
  localparam int unsigned STACK_LEVELS_DEF = 4;
  localparam int unsigned PC_BITS_DEF = 12;

  typedef enum logic [2:0] {
    IO_NONE = 3'd0, IO_RAM_WRITE = 3'd1, IO_RAM_PORT = 3'd2, IO_ROM_PORT = 3'd3,
    IO_STATUS = 3'd4, IO_SRC = 3'd5, IO_BANK = 3'd6
  } io_action_t;

  localparam logic [3:0] OP_JCN = 4'h1, OP_FIM = 4'h2, OP_JIN = 4'h3, OP_JUN = 4'h4,
    OP_JMS = 4'h5, OP_INC = 4'h6, OP_ISZ = 4'h7, OP_ADD = 4'h8, OP_SUB = 4'h9,
    OP_LD = 4'hA, OP_XCH = 4'hB, OP_BBL = 4'hC, OP_LDM = 4'hD, OP_IO = 4'hE,
    OP_ACC = 4'hF;
endpackage

>>> rtl/ncpu_if.sv
interface ncpu_in_if;
  logic valid;
  logic ready;
  logic [7:0] opcode;
  logic [7:0] operand_byte;
  logic [3:0] memory_nibble;
  logic test_pin;
  modport source (output valid, opcode, operand_byte, memory_nibble, test_pin, input ready);
  modport sink (input valid, opcode, operand_byte, memory_nibble, test_pin, output ready);
endinterface

interface ncpu_out_if;
  logic valid;
  logic ready;
  logic [11:0] program_counter;
  logic [3:0] accumulator_out;
  logic carry_out;
  logic [2:0] io_action;
  logic [7:0] io_data;
  logic [1:0] status_select;
  logic stack_overflow;
  modport source (output valid, program_counter, accumulator_out, carry_out, io_action,
    io_data, status_select, stack_overflow, input ready);
  modport sink (input valid, program_counter, accumulator_out, carry_out, io_action,
    io_data, status_select, stack_overflow, output ready);
endinterface

>>> rtl/nibble_cpu_execute_unit.sv
// Each result item is registered from its accepted input item.
// Throughput: one instruction per cycle unless the sink stalls; the architectural state updates as each
// item is accepted, so the next item sees it at once.
// The output register holds a result while the sink stalls; input ready follows it.
// Reset (synchronous): accumulator, carry, index registers, stack and level clear.
module nibble_cpu_execute_unit import ncpu_pkg::*; #(
  parameter int unsigned STACK_LEVELS = STACK_LEVELS_DEF,
  parameter int unsigned PC_BITS = PC_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  ncpu_in_if.sink   in_ch,
  ncpu_out_if.source out_ch
);
  localparam int unsigned LW = (STACK_LEVELS > 1) ? $clog2(STACK_LEVELS) : 1;
  localparam logic [PC_BITS-1:0] PAGE_MASK = {{(PC_BITS-8){1'b1}}, 8'h00};

  logic [3:0] accumulator, accumulator_next;
  logic carry_flag, carry_next;
  logic [3:0] index_registers [16];
  logic [PC_BITS-1:0] address_stack [STACK_LEVELS];
  logic [LW-1:0] stack_level, lvl_next;
  logic [LW-1:0] lvl_dec;
  logic [PC_BITS-1:0] pc, next1, next2, newpc, saved;
  logic save_en, reg_wr, reg_wr2;
  logic [3:0] reg_idx, reg_val, reg_val2;
  logic [2:0] io;
  logic [7:0] iod;
  logic [1:0] ssel;
  logic ovf, cond, accept;
  logic [3:0] hi, lo, r, rinc;
  logic [7:0] byte_in, pairv;
  logic [4:0] sum;
  logic [4:0] daa;

  assign accept = in_ch.valid && in_ch.ready;
  assign in_ch.ready = !out_ch.valid || out_ch.ready;

  assign hi = in_ch.opcode[7:4];
  assign lo = in_ch.opcode[3:0];
  assign byte_in = in_ch.operand_byte;
  assign pc = address_stack[stack_level];
  assign next1 = pc + PC_BITS'(1);
  assign next2 = pc + PC_BITS'(2);
  assign r = index_registers[lo];
  assign rinc = r + 4'd1;
  assign pairv = {index_registers[{lo[3:1], 1'b0}], index_registers[{lo[3:1], 1'b1}]};
  assign lvl_dec = (stack_level == '0) ? LW'(STACK_LEVELS - 1) : stack_level - LW'(1);
  assign daa = {1'b0, accumulator} + 5'd6;

  always_comb begin
    accumulator_next = accumulator;
    carry_next = carry_flag;
    lvl_next = stack_level;
    newpc = next1;
    save_en = 1'b0;
    saved = next2;
    reg_wr = 1'b0;
    reg_wr2 = 1'b0;
    reg_idx = lo;
    reg_val = rinc;
    reg_val2 = byte_in[3:0];
    io = IO_NONE;
    iod = 8'd0;
    ssel = 2'd0;
    ovf = 1'b0;
    sum = 5'd0;
    cond = ((lo[2] && accumulator == 4'd0) || (lo[1] && carry_flag) ||
            (lo[0] && !in_ch.test_pin)) ^ lo[3];
    unique case (hi)
      OP_JCN: newpc = cond ? ((next2 & PAGE_MASK) | PC_BITS'(byte_in)) : next2;
      OP_FIM: begin
        if (!lo[0]) begin
          reg_wr = 1'b1; reg_wr2 = 1'b1;
          reg_idx = {lo[3:1], 1'b0}; reg_val = byte_in[7:4];
          newpc = next2;
        end else begin
          io = IO_SRC; iod = pairv;
        end
      end
      OP_JIN: if (lo[0]) newpc = (next1 & PAGE_MASK) | PC_BITS'(pairv);
      OP_JUN: newpc = PC_BITS'({lo, byte_in});
      OP_JMS: begin
        save_en = 1'b1;
        if (stack_level == LW'(STACK_LEVELS - 1)) begin
          lvl_next = '0; ovf = 1'b1;
        end else lvl_next = stack_level + LW'(1);
        newpc = PC_BITS'({lo, byte_in});
      end
      OP_INC: reg_wr = 1'b1;
      OP_ISZ: begin
        reg_wr = 1'b1;
        newpc = (rinc != 4'd0) ? ((next2 & PAGE_MASK) | PC_BITS'(byte_in)) : next2;
      end
      OP_ADD: sum = {1'b0, accumulator} + {1'b0, r} + {4'd0, carry_flag};
      OP_SUB: sum = {1'b0, accumulator} + {1'b0, ~r} + {4'd0, ~carry_flag};
      OP_LD: accumulator_next = r;
      OP_XCH: begin
        accumulator_next = r; reg_wr = 1'b1; reg_val = accumulator;
      end
      OP_BBL: begin
        lvl_next = lvl_dec; newpc = address_stack[lvl_dec]; accumulator_next = lo;
      end
      OP_LDM: accumulator_next = lo;
      OP_IO: begin
        unique case (lo)
          4'h0: begin io = IO_RAM_WRITE; iod = {4'd0, accumulator}; end
          4'h1: begin io = IO_RAM_PORT; iod = {4'd0, accumulator}; end
          4'h2: begin io = IO_ROM_PORT; iod = {4'd0, accumulator}; end
          4'h4, 4'h5, 4'h6, 4'h7: begin
            io = IO_STATUS; iod = {4'd0, accumulator}; ssel = lo[1:0];
          end
          4'h8: sum = {1'b0, accumulator} + {1'b0, ~in_ch.memory_nibble} +
                      {4'd0, ~carry_flag};
          4'hB: sum = {1'b0, accumulator} + {1'b0, in_ch.memory_nibble} +
                      {4'd0, carry_flag};
          4'h9, 4'hA, 4'hC, 4'hD, 4'hE, 4'hF: accumulator_next = in_ch.memory_nibble;
          default: ;
        endcase
        if (lo == 4'h8 || lo == 4'hB) begin
          accumulator_next = sum[3:0]; carry_next = sum[4];
        end
      end
      OP_ACC: begin
        unique case (lo)
          4'h0: begin accumulator_next = 4'd0; carry_next = 1'b0; end
          4'h1: carry_next = 1'b0;
          4'h2: begin
            sum = {1'b0, accumulator} + 5'd1;
            accumulator_next = sum[3:0]; carry_next = sum[4];
          end
          4'h3: carry_next = ~carry_flag;
          4'h4: accumulator_next = ~accumulator;
          4'h5: begin accumulator_next = {accumulator[2:0], carry_flag};
            carry_next = accumulator[3]; end
          4'h6: begin accumulator_next = {carry_flag, accumulator[3:1]};
            carry_next = accumulator[0]; end
          4'h7: begin accumulator_next = {3'd0, carry_flag}; carry_next = 1'b0; end
          4'h8: begin
            sum = {1'b0, accumulator} + 5'd15;
            accumulator_next = sum[3:0]; carry_next = sum[4];
          end
          4'h9: begin accumulator_next = carry_flag ? 4'd10 : 4'd9; carry_next = 1'b0; end
          4'hA: carry_next = 1'b1;
          4'hB: if (accumulator > 4'd9 || carry_flag) begin
            accumulator_next = daa[3:0];
            if (daa[4]) carry_next = 1'b1;
          end
          4'hC: begin
            priority case (accumulator)
              4'd0, 4'd1, 4'd2: ;
              4'd4: accumulator_next = 4'd3;
              4'd8: accumulator_next = 4'd4;
              default: accumulator_next = 4'd15;
            endcase
          end
          4'hD: begin
            if (accumulator[2:0] == 3'd0 || accumulator[2:0] == 3'd1 ||
                accumulator[2:0] == 3'd2) begin
              io = IO_BANK; iod = {5'd0, accumulator[2:0]};
            end else if (accumulator[2:0] == 3'd4) begin
              io = IO_BANK; iod = 8'd3;
            end
          end
          default: ;
        endcase
      end
      default: ;
    endcase
    if (hi == OP_ADD || hi == OP_SUB) begin
      accumulator_next = sum[3:0]; carry_next = sum[4];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      accumulator <= 4'd0;
      carry_flag <= 1'b0;
      stack_level <= '0;
      for (int i = 0; i < 16; i++) index_registers[i] <= 4'd0;
      for (int i = 0; i < STACK_LEVELS; i++) address_stack[i] <= '0;
    end else if (accept) begin
      accumulator <= accumulator_next;
      carry_flag <= carry_next;
      stack_level <= lvl_next;
      if (save_en) address_stack[stack_level] <= saved;
      address_stack[lvl_next] <= newpc;
      if (reg_wr) index_registers[reg_idx] <= reg_val;
      if (reg_wr2) index_registers[{lo[3:1], 1'b1}] <= reg_val2;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) out_ch.valid <= 1'b0;
    else if (in_ch.ready) out_ch.valid <= in_ch.valid;
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_ch.program_counter <= 12'(newpc);
      out_ch.accumulator_out <= accumulator_next;
      out_ch.carry_out <= carry_next;
      out_ch.io_action <= io;
      out_ch.io_data <= iod;
      out_ch.status_select <= ssel;
      out_ch.stack_overflow <= ovf;
    end
  end

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.program_counter))
    else $error("result changed while stalled");
  a_ovf_jms: assert property (@(posedge clk) disable iff (rst)
    accept && ovf |=> stack_level == '0)
    else $error("overflow without level wrap");
  a_ssel: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && out_ch.io_action != IO_STATUS |-> out_ch.status_select == 2'd0)
    else $error("status select without status write");
endmodule
